FILE: rtl/core/arlp_pkg.sv
// ----------------------------------------------------------------------------
// arlp_pkg
// Shared types, character codes and prefix text for the AT response parser.
// ----------------------------------------------------------------------------
package arlp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Prefix text, first character in the top byte
  localparam int unsigned COPS_LEN = 9;
  localparam int unsigned CSQ_LEN  = 5;
  localparam logic [8*COPS_LEN-1:0] COPS_TEXT = "+COPS: 0,";
  localparam logic [8*CSQ_LEN-1:0]  CSQ_TEXT  = "+CSQ:";

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_NO_OP  = 2'd2,
    KIND_SIGNAL = 2'd3
  } line_kind_e;

  typedef enum logic [1:0] {
    NAME_SEEK,
    NAME_SKIP,
    NAME_COLLECT,
    NAME_DONE
  } name_phase_e;

  typedef enum logic [1:0] {
    SIG_SEEK,
    SIG_SKIP,
    SIG_TOKEN,
    SIG_DONE
  } sig_phase_e;

  typedef enum logic [1:0] {
    ATOI_BLANK,
    ATOI_DIGITS,
    ATOI_STOP
  } atoi_state_e;

  // Line summary handed from the scanner to the emitter at newline
  typedef struct packed {
    line_kind_e  kind;
    logic [7:0]  level;
  } line_sum_t;

  // Character i of a prefix text of n characters
  function automatic logic [7:0] text_char(input logic [8*COPS_LEN-1:0] s,
                                           input int unsigned n,
                                           input logic [3:0] i);
    int unsigned sel;
    sel = n - 1 - int'(i);
    return s[8*sel +: 8];
  endfunction

endpackage

FILE: rtl/core/arlp_rx_if.sv
// ----------------------------------------------------------------------------
// arlp_rx_if
// Receive byte channel: valid, ready and one byte per item.
// ----------------------------------------------------------------------------
interface arlp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/arlp_res_if.sv
// ----------------------------------------------------------------------------
// arlp_res_if
// Result channel: one classified line, or one operator name character, per item.
// ----------------------------------------------------------------------------
interface arlp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_kind;
  logic [7:0] signal_level;
  logic [7:0] name_char;
  logic [4:0] name_index;
  logic [4:0] name_length;
  logic       last;

  modport source (output valid, output line_kind, output signal_level,
                  output name_char, output name_index, output name_length,
                  output last, input ready);
  modport sink   (input valid, input line_kind, input signal_level,
                  input name_char, input name_index, input name_length,
                  input last, output ready);
endinterface

FILE: rtl/core/arlp_line_scan.sv
// ----------------------------------------------------------------------------
// arlp_line_scan
// Per-byte line scanner: prefix match, name capture and signal conversion.
// ----------------------------------------------------------------------------
module arlp_line_scan
  import arlp_pkg::*;
#(
  parameter int unsigned LINE_MAX     = 75,
  parameter int unsigned NAME_MAX     = 20,
  parameter int unsigned SIGNAL_CHARS = 4,
  localparam int unsigned PW = $clog2(LINE_MAX + 1),
  localparam int unsigned CW = $clog2(NAME_MAX + 1),
  localparam int unsigned AW = $clog2(2 * NAME_MAX)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output line_sum_t     sum_o,
  output logic [CW-1:0] name_len_o,
  output logic          bank_o
);

  localparam int unsigned TW = $clog2(SIGNAL_CHARS + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic          ended_q, ended_d;
  logic [3:0]    cops_cnt_q, cops_cnt_d;
  logic          cops_miss_q, cops_miss_d;
  logic [3:0]    csq_cnt_q, csq_cnt_d;
  logic          csq_miss_q, csq_miss_d;
  name_phase_e   name_phase_q, name_phase_d;
  logic [CW-1:0] name_cnt_q, name_cnt_d;
  sig_phase_e    sig_phase_q, sig_phase_d;
  logic [TW-1:0] tok_cnt_q, tok_cnt_d;
  atoi_state_e   atoi_q, atoi_d;
  logic [7:0]    acc_q, acc_d;
  logic          neg_q, neg_d;
  logic [7:0]    level_q, level_d;
  logic          bank_q, bank_d;

  logic          plain, store, counted, lf;
  logic          is_quote;
  atoi_state_e   st_in, st_out;
  logic [7:0]    acc_in, acc_out, digit;
  logic          neg_in, neg_out, is_digit, is_blank;
  logic [CW-1:0] wr_idx;

  assign plain    = byte_valid_i && (byte_i != CH_CR) && (byte_i != CH_LF);
  assign store    = plain && (pos_q < PW'(LINE_MAX));
  assign counted  = store && !ended_q && (byte_i != CH_NUL);
  assign lf       = byte_valid_i && (byte_i == CH_LF);
  assign is_quote = (byte_i == CH_QUOTE);

  // One conversion step; a token's first character starts from a fresh state
  always_comb begin
    st_in    = (sig_phase_q == SIG_SKIP) ? ATOI_BLANK : atoi_q;
    acc_in   = (sig_phase_q == SIG_SKIP) ? 8'd0 : acc_q;
    neg_in   = (sig_phase_q == SIG_SKIP) ? 1'b0 : neg_q;
    is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    is_blank = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
    digit    = byte_i - CH_ZERO;
    st_out   = st_in;
    acc_out  = acc_in;
    neg_out  = neg_in;
    case (st_in)
      ATOI_BLANK: begin
        if (is_blank) begin
          st_out = ATOI_BLANK;
        end else if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
          neg_out = (byte_i == CH_MINUS);
          st_out  = ATOI_DIGITS;
        end else if (is_digit) begin
          acc_out = digit;
          st_out  = ATOI_DIGITS;
        end else begin
          st_out = ATOI_STOP;
        end
      end
      ATOI_DIGITS: begin
        if (is_digit) begin
          acc_out = {acc_in[4:0], 3'b000} + {acc_in[6:0], 1'b0} + digit;
        end else begin
          st_out = ATOI_STOP;
        end
      end
      default: ;
    endcase
  end

  // Line summary from the state before the newline
  always_comb begin
    sum_o.level = level_q;
    if (cops_cnt_q == 4'(COPS_LEN)) begin
      sum_o.kind = KIND_NAME;
    end else if (cops_cnt_q == 4'(COPS_LEN - 1)) begin
      sum_o.kind = KIND_NO_OP;
    end else if (csq_cnt_q == 4'(CSQ_LEN)) begin
      sum_o.kind = KIND_SIGNAL;
      if (tok_cnt_q != '0) begin
        sum_o.level = neg_q ? (8'd0 - acc_q) : acc_q;
      end
    end else begin
      sum_o.kind = KIND_OTHER;
    end
  end

  // Only an operator report carries a name run
  assign name_len_o = (sum_o.kind == KIND_NAME) ? name_cnt_q : '0;
  assign bank_o     = bank_q;

  // Next state
  always_comb begin
    pos_d        = pos_q;
    ended_d      = ended_q;
    cops_cnt_d   = cops_cnt_q;
    cops_miss_d  = cops_miss_q;
    csq_cnt_d    = csq_cnt_q;
    csq_miss_d   = csq_miss_q;
    name_phase_d = name_phase_q;
    name_cnt_d   = name_cnt_q;
    sig_phase_d  = sig_phase_q;
    tok_cnt_d    = tok_cnt_q;
    atoi_d       = atoi_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    level_d      = level_q;
    bank_d       = bank_q;

    if (store) begin
      pos_d = pos_q + PW'(1);
      if (byte_i == CH_NUL) begin
        ended_d = 1'b1;
      end
    end

    if (counted) begin
      if (!cops_miss_q && (cops_cnt_q < 4'(COPS_LEN))) begin
        if (byte_i == text_char(COPS_TEXT, COPS_LEN, cops_cnt_q)) begin
          cops_cnt_d = cops_cnt_q + 4'd1;
        end else begin
          cops_miss_d = 1'b1;
        end
      end
      if (!csq_miss_q && (csq_cnt_q < 4'(CSQ_LEN))) begin
        if (byte_i == text_char((8*COPS_LEN)'(CSQ_TEXT), CSQ_LEN, csq_cnt_q)) begin
          csq_cnt_d = csq_cnt_q + 4'd1;
        end else begin
          csq_miss_d = 1'b1;
        end
      end

      case (name_phase_q)
        NAME_SEEK: begin
          if (is_quote) name_phase_d = NAME_SKIP;
        end
        NAME_SKIP: begin
          if (!is_quote) begin
            name_cnt_d   = CW'(1);
            name_phase_d = NAME_COLLECT;
          end
        end
        NAME_COLLECT: begin
          if (is_quote) begin
            name_phase_d = NAME_DONE;
          end else if (name_cnt_q < CW'(NAME_MAX)) begin
            name_cnt_d = name_cnt_q + CW'(1);
          end
        end
        default: ;
      endcase

      case (sig_phase_q)
        SIG_SEEK: begin
          if (byte_i == CH_SPACE) sig_phase_d = SIG_SKIP;
        end
        SIG_SKIP: begin
          if (!is_quote) begin
            sig_phase_d = SIG_TOKEN;
            tok_cnt_d   = TW'(1);
            atoi_d      = st_out;
            acc_d       = acc_out;
            neg_d       = neg_out;
          end
        end
        SIG_TOKEN: begin
          if (is_quote) begin
            sig_phase_d = SIG_DONE;
          end else if (tok_cnt_q < TW'(SIGNAL_CHARS)) begin
            tok_cnt_d = tok_cnt_q + TW'(1);
            atoi_d    = st_out;
            acc_d     = acc_out;
            neg_d     = neg_out;
          end
        end
        default: ;
      endcase
    end

    // Newline: commit the level, swap name banks, start a fresh line
    if (lf) begin
      pos_d        = '0;
      ended_d      = 1'b0;
      cops_cnt_d   = '0;
      cops_miss_d  = 1'b0;
      csq_cnt_d    = '0;
      csq_miss_d   = 1'b0;
      name_phase_d = NAME_SEEK;
      name_cnt_d   = '0;
      sig_phase_d  = SIG_SEEK;
      tok_cnt_d    = '0;
      atoi_d       = ATOI_BLANK;
      acc_d        = '0;
      neg_d        = 1'b0;
      level_d      = sum_o.level;
      bank_d       = !bank_q;
    end
  end

  // Name memory write port
  always_comb begin
    wr_en_o   = 1'b0;
    wr_idx    = name_cnt_q;
    wr_data_o = byte_i;
    if (counted && !is_quote) begin
      if (name_phase_q == NAME_SKIP) begin
        wr_en_o = 1'b1;
        wr_idx  = '0;
      end else if ((name_phase_q == NAME_COLLECT) && (name_cnt_q < CW'(NAME_MAX))) begin
        wr_en_o = 1'b1;
      end
    end
    wr_addr_o = bank_q ? (AW'(NAME_MAX) + AW'(wr_idx)) : AW'(wr_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ended_q      <= 1'b0;
      cops_cnt_q   <= '0;
      cops_miss_q  <= 1'b0;
      csq_cnt_q    <= '0;
      csq_miss_q   <= 1'b0;
      name_phase_q <= NAME_SEEK;
      name_cnt_q   <= '0;
      sig_phase_q  <= SIG_SEEK;
      tok_cnt_q    <= '0;
      atoi_q       <= ATOI_BLANK;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      level_q      <= '0;
      bank_q       <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      ended_q      <= ended_d;
      cops_cnt_q   <= cops_cnt_d;
      cops_miss_q  <= cops_miss_d;
      csq_cnt_q    <= csq_cnt_d;
      csq_miss_q   <= csq_miss_d;
      name_phase_q <= name_phase_d;
      name_cnt_q   <= name_cnt_d;
      sig_phase_q  <= sig_phase_d;
      tok_cnt_q    <= tok_cnt_d;
      atoi_q       <= atoi_d;
      acc_q        <= acc_d;
      neg_q        <= neg_d;
      level_q      <= level_d;
      bank_q       <= bank_d;
    end
  end

endmodule

FILE: rtl/core/arlp_run_emitter.sv
// ----------------------------------------------------------------------------
// arlp_run_emitter
// Name memory and result sequencer: one result per name character, or one
// result per line, through a read stage and an output register.
// ----------------------------------------------------------------------------
module arlp_run_emitter
  import arlp_pkg::*;
#(
  parameter int unsigned NAME_MAX = 20,
  localparam int unsigned CW = $clog2(NAME_MAX + 1),
  localparam int unsigned AW = $clog2(2 * NAME_MAX)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              load_i,
  input  line_sum_t         sum_i,
  input  logic [CW-1:0]     name_len_i,
  input  logic              bank_i,
  output logic              can_load_o,
  arlp_res_if.source        res
);

  logic [7:0] name_mem [2*NAME_MAX];

  // Run sequencer
  logic          seq_active_q;
  logic [CW-1:0] seq_idx_q, seq_len_q;
  logic          seq_bank_q;
  line_kind_e    seq_kind_q;
  logic [7:0]    seq_level_q;

  // Read stage
  logic          s1_valid_q;
  logic          s1_is_name_q, s1_last_q;
  logic [CW-1:0] s1_idx_q, s1_len_q;
  line_kind_e    s1_kind_q;
  logic [7:0]    s1_level_q;
  logic [7:0]    rd_data_q;

  // Output register
  logic          out_valid_q;
  line_kind_e    out_kind_q;
  logic [7:0]    out_level_q, out_char_q;
  logic [4:0]    out_index_q, out_length_q;
  logic          out_last_q;

  logic          move_out, s1_free, issue, run_last;
  logic [AW-1:0] rd_addr;

  assign move_out   = s1_valid_q && (!out_valid_q || res.ready);
  assign s1_free    = !s1_valid_q || move_out;
  assign issue      = seq_active_q && s1_free;
  assign run_last   = (seq_len_q == '0) || (CW'(seq_idx_q + CW'(1)) == seq_len_q);
  assign can_load_o = !seq_active_q || (issue && run_last);
  assign rd_addr    = seq_bank_q ? (AW'(NAME_MAX) + AW'(seq_idx_q)) : AW'(seq_idx_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      name_mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= name_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_active_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_i) begin
        seq_active_q <= 1'b1;
      end else if (issue && run_last) begin
        seq_active_q <= 1'b0;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (move_out) begin
        s1_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold unless advancing
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seq_idx_q   <= '0;
      seq_len_q   <= name_len_i;
      seq_bank_q  <= bank_i;
      seq_kind_q  <= sum_i.kind;
      seq_level_q <= sum_i.level;
    end else if (issue) begin
      seq_idx_q <= seq_idx_q + CW'(1);
    end
    if (issue) begin
      s1_is_name_q <= (seq_len_q != '0);
      s1_last_q    <= run_last;
      s1_idx_q     <= seq_idx_q;
      s1_len_q     <= seq_len_q;
      s1_kind_q    <= seq_kind_q;
      s1_level_q   <= seq_level_q;
    end
    if (move_out) begin
      out_kind_q   <= s1_kind_q;
      out_level_q  <= s1_level_q;
      out_char_q   <= s1_is_name_q ? rd_data_q : 8'd0;
      out_index_q  <= s1_is_name_q ? 5'(s1_idx_q) : 5'd0;
      out_length_q <= 5'(s1_len_q);
      out_last_q   <= s1_last_q;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.line_kind    = out_kind_q;
  assign res.signal_level = out_level_q;
  assign res.name_char    = out_char_q;
  assign res.name_index   = out_index_q;
  assign res.name_length  = out_length_q;
  assign res.last         = out_last_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("new line loaded while a run is still issuing");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && run_last && !load_i) |=> !seq_active_q)
    else $error("sequencer still active after the last item of its run");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !move_out) |=> (s1_valid_q && $stable(rd_data_q)))
    else $error("read stage lost its character while stalled");

  a_index_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_length_q != 5'd0)) |-> (out_index_q < out_length_q))
    else $error("name index beyond name length");
`endif

endmodule

FILE: rtl/core/at_response_line_parser.sv
// ----------------------------------------------------------------------------
// at_response_line_parser
// Modem AT response line parser: classifies lines and reports operator name
// and signal level.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle. Carriage returns are dropped,
// only the first LINE_MAX bytes of a line count, and a zero byte ends the
// text of its line. A newline produces one result item, or one item per name
// character for an operator report, emitted at one item per cycle while the
// result side takes every item, through the name memory's single read port.
// A newline is held off only while the previous line's run still has items
// to issue; other bytes are never held off. A newline that follows a run of
// name characters closely is held until the run's last item issues; a
// stalled result side holds it for as long as the stall lasts. Results go
// out through a registered output stage.
module at_response_line_parser
  import arlp_pkg::*;
#(
  parameter int unsigned LINE_MAX     = 75,
  parameter int unsigned NAME_MAX     = 20,
  parameter int unsigned SIGNAL_CHARS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arlp_rx_if.sink     rx_i,
  arlp_res_if.source  res_o
);

  localparam int unsigned CW = $clog2(NAME_MAX + 1);
  localparam int unsigned AW = $clog2(2 * NAME_MAX);

  logic          rx_accept;
  logic          lf_load;
  logic          can_load;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  line_sum_t     line_sum;
  logic [CW-1:0] name_len;
  logic          bank;

  // Hold a newline until the sequencer can take the next line
  assign rx_i.ready = (rx_i.rx_byte != CH_LF) || can_load;
  assign rx_accept  = rx_i.valid && rx_i.ready;
  assign lf_load    = rx_accept && (rx_i.rx_byte == CH_LF);

  // Scan each byte: prefix match, quoted name capture, signal token conversion
  arlp_line_scan #(
    .LINE_MAX     (LINE_MAX),
    .NAME_MAX     (NAME_MAX),
    .SIGNAL_CHARS (SIGNAL_CHARS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (rx_accept),
    .byte_i       (rx_i.rx_byte),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .sum_o        (line_sum),
    .name_len_o   (name_len),
    .bank_o       (bank)
  );

  // Name characters live in two banks: one fills while the other is read out
  arlp_run_emitter #(
    .NAME_MAX (NAME_MAX)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .load_i     (lf_load),
    .sum_i      (line_sum),
    .name_len_i (name_len),
    .bank_i     (bank),
    .can_load_o (can_load),
    .res        (res_o)
  );

endmodule
